// ===== rtl/core/fsc_pkg.sv =====
// Shared types and constants for the dual fan speed controller.
// No dependencies; used by fsc_div and dual_fan_speed_controller.
package fsc_pkg;

  localparam int TEMP_W  = 12;
  localparam int PCT_W   = 7;
  localparam int CMD_W   = 2;
  localparam int DVD_W   = 20;  // 2*100*(T-on) + den, fits below 2^20
  localparam int DVS_W   = 13;  // 2*den
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE = 2'd0,
    CMD_STOP = 2'd1,
    CMD_SET  = 2'd2
  } fsc_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAP_ON   = 3'd0,
    REG_CAP_FULL = 3'd1,
    REG_CAP_OFF  = 3'd2,
    REG_HS_ON    = 3'd3,
    REG_HS_FULL  = 3'd4,
    REG_HS_OFF   = 3'd5,
    REG_MIN_RUN  = 3'd6,
    REG_DEADBAND = 3'd7
  } fsc_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } fsc_state_t;

  typedef struct packed {
    logic                     supply_present;
    logic signed [TEMP_W-1:0] heatsink_temp;
    logic                     heatsink_valid;
    logic signed [TEMP_W-1:0] board0_temp;
    logic                     board0_valid;
    logic signed [TEMP_W-1:0] board1_temp;
    logic                     board1_valid;
  } fsc_in_t;

  typedef struct packed {
    logic [CMD_W-1:0] cap_command;
    logic [PCT_W-1:0] cap_speed;
    logic [CMD_W-1:0] hs_command;
    logic [PCT_W-1:0] hs_speed;
  } fsc_out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PCT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/fsc_div.sv =====
// Restoring divider, one quotient bit per cycle, 7-bit quotient.
// Depends on fsc_pkg. Caller guarantees dividend < 128 * divisor.
module fsc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  fsc_pkg::div_req_t req,
  output fsc_pkg::div_rsp_t rsp
);

  localparam int STEPS = fsc_pkg::PCT_W;
  localparam int CW    = $clog2(STEPS);

  logic [fsc_pkg::DVD_W-1:0] rem_r, rem_nxt;
  logic [fsc_pkg::DVD_W-1:0] dsh_r, dsh_nxt;
  logic [fsc_pkg::PCT_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic                      ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend;
      // divisor aligned to the top quotient bit
      dsh_nxt  = fsc_pkg::DVD_W'({req.divisor, (STEPS-1)'(0)});
      cnt_nxt  = CW'(STEPS-1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[fsc_pkg::PCT_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/core/dual_fan_speed_controller.sv =====
// Top level of the dual fan speed controller.
// Depends on fsc_pkg and fsc_div.
//
// One request is one control tick and yields exactly one result. With the
// supply absent a running fan gets a stop; otherwise the capacitor fan follows
// the hotter valid board sensor and the heatsink fan its own sensor, each
// through an off/on/full curve with hysteresis, minimum run speed and a
// deadband on speed changes. The two channels are evaluated in turn and share
// one 7-step restoring divider for the ramp. A tick passes ST_PREP once per
// channel, with a divide in ST_DIV after the PREP of a ramp channel, then
// ST_DONE, which registers the result; without supply it goes straight to
// ST_DONE. in_ready is high only while the sequencer is idle; a finished
// result waits in the output register and does not block the next request.
// The config port never stalls; write it only while the block is idle.
module dual_fan_speed_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick request
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fsc_pkg::fsc_in_t                  in_data,
  // result
  output logic                              out_valid,
  input  logic                              out_ready,
  output fsc_pkg::fsc_out_t                 out_data,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsc_pkg::TEMP_W-1:0]        cfg_data
);

  localparam int TW = fsc_pkg::TEMP_W;
  localparam int PW = fsc_pkg::PCT_W;
  localparam int MW = 19;  // 100 * 4095 and 127 * 4095 both fit

  localparam logic signed [TW-1:0] CAP_ON_RST   = 12'sd720;
  localparam logic signed [TW-1:0] CAP_FULL_RST = 12'sd960;
  localparam logic signed [TW-1:0] CAP_OFF_RST  = 12'sd640;
  localparam logic signed [TW-1:0] HS_ON_RST    = 12'sd800;
  localparam logic signed [TW-1:0] HS_FULL_RST  = 12'sd1120;
  localparam logic signed [TW-1:0] HS_OFF_RST   = 12'sd720;
  localparam logic [PW-1:0]        MIN_RUN_RST  = 7'd20;
  localparam logic [PW-1:0]        DEADBAND_RST = 7'd5;
  localparam logic [PW-1:0]        PCT_FULL     = 7'd100;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] cap_on_r, cap_full_r, cap_off_r;
  logic signed [TW-1:0] hs_on_r, hs_full_r, hs_off_r;
  logic [PW-1:0]        min_run_r, deadband_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_on_r   <= CAP_ON_RST;
      cap_full_r <= CAP_FULL_RST;
      cap_off_r  <= CAP_OFF_RST;
      hs_on_r    <= HS_ON_RST;
      hs_full_r  <= HS_FULL_RST;
      hs_off_r   <= HS_OFF_RST;
      min_run_r  <= MIN_RUN_RST;
      deadband_r <= DEADBAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fsc_pkg::fsc_reg_t'(cfg_index))
        fsc_pkg::REG_CAP_ON:   cap_on_r   <= cfg_data;
        fsc_pkg::REG_CAP_FULL: cap_full_r <= cfg_data;
        fsc_pkg::REG_CAP_OFF:  cap_off_r  <= cfg_data;
        fsc_pkg::REG_HS_ON:    hs_on_r    <= cfg_data;
        fsc_pkg::REG_HS_FULL:  hs_full_r  <= cfg_data;
        fsc_pkg::REG_HS_OFF:   hs_off_r   <= cfg_data;
        fsc_pkg::REG_MIN_RUN:  min_run_r  <= cfg_data[PW-1:0];
        fsc_pkg::REG_DEADBAND: deadband_r <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  fsc_pkg::fsc_state_t state_r, state_nxt;
  logic                ch_r, ch_nxt;        // 0: capacitor, 1: heatsink
  fsc_pkg::fsc_in_t    in_r;
  logic [PW-1:0]       np_r, np_nxt;        // new capacitor percent
  logic [PW-1:0]       nh_r, nh_nxt;        // new heatsink percent
  logic [PW-1:0]       last_cap_r, last_cap_nxt;
  logic [PW-1:0]       last_hs_r, last_hs_nxt;
  fsc_pkg::fsc_out_t   out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  fsc_pkg::div_req_t   div_req;
  fsc_pkg::div_rsp_t   div_rsp;

  logic in_acc;
  logic out_free;

  assign in_ready = (state_r == fsc_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Curve evaluation for the channel under ch_r
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0]   cap_t;
  logic                   cap_v;
  logic signed [TW-1:0]   t_sel, on_sel, full_sel, off_sel;
  logic                   v_sel;
  logic [PW-1:0]          last_sel;
  logic signed [TW:0]     d_s, den_s;
  logic [TW-1:0]          d_u, den_u;
  logic [MW-1:0]          num, min_prod;
  logic [PW-1:0]          direct_pct;
  logic                   need_div;

  always_comb begin
    // hotter valid board sensor feeds the capacitor channel
    priority if (in_r.board0_valid && in_r.board1_valid) begin
      cap_t = (in_r.board0_temp > in_r.board1_temp) ? in_r.board0_temp
                                                     : in_r.board1_temp;
    end else if (in_r.board0_valid) begin
      cap_t = in_r.board0_temp;
    end else begin
      cap_t = in_r.board1_temp;
    end
    cap_v = in_r.board0_valid || in_r.board1_valid;

    if (ch_r) begin
      t_sel    = in_r.heatsink_temp;
      v_sel    = in_r.heatsink_valid;
      on_sel   = hs_on_r;
      full_sel = hs_full_r;
      off_sel  = hs_off_r;
      last_sel = last_hs_r;
    end else begin
      t_sel    = cap_t;
      v_sel    = cap_v;
      on_sel   = cap_on_r;
      full_sel = cap_full_r;
      off_sel  = cap_off_r;
      last_sel = last_cap_r;
    end

    d_s   = (TW+1)'(t_sel) - (TW+1)'(on_sel);
    den_s = (TW+1)'(full_sel) - (TW+1)'(on_sel);
    // on the ramp both are nonnegative and below 2^12
    d_u   = d_s[TW-1:0];
    den_u = den_s[TW-1:0];
    num      = MW'(d_u) * MW'(PCT_FULL);
    min_prod = MW'(min_run_r) * MW'(den_u);

    need_div   = 1'b0;
    direct_pct = last_sel;
    priority if (!v_sel) begin
      direct_pct = last_sel;
    end else if (t_sel <= off_sel) begin
      direct_pct = '0;
    end else if (t_sel < on_sel) begin
      direct_pct = last_sel;
    end else if (t_sel >= full_sel) begin
      direct_pct = PCT_FULL;
    end else if ((num != '0) && (num < min_prod)) begin
      direct_pct = min_run_r;
    end else begin
      need_div = 1'b1;
    end
  end

  // round to nearest: (2*num + den) / (2*den)
  assign div_req.start    = (state_r == fsc_pkg::ST_PREP) && need_div;
  assign div_req.dividend = fsc_pkg::DVD_W'({num, 1'b0}) + fsc_pkg::DVD_W'(den_u);
  assign div_req.divisor  = {den_u, 1'b0};

  fsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Command decision: stop on a drop to zero, set on a deadband-sized change
  // ---------------------------------------------------------------------------
  typedef struct packed {
    fsc_pkg::fsc_cmd_t cmd;
    logic [PW-1:0]     last;
  } dec_t;

  function automatic dec_t decide(input logic [PW-1:0] n,
                                  input logic [PW-1:0] last,
                                  input logic [PW-1:0] band);
    dec_t          r;
    logic [PW-1:0] diff;
    diff   = (n > last) ? (n - last) : (last - n);
    r.cmd  = fsc_pkg::CMD_NONE;
    r.last = last;
    if (n == '0) begin
      if (last != '0) begin
        r.cmd  = fsc_pkg::CMD_STOP;
        r.last = '0;
      end
    end else if (diff >= band) begin
      r.cmd  = fsc_pkg::CMD_SET;
      r.last = n;
    end
    return r;
  endfunction

  dec_t cap_dec, hs_dec;
  assign cap_dec = decide(np_r, last_cap_r, deadband_r);
  assign hs_dec  = decide(nh_r, last_hs_r, deadband_r);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          // supply loss goes straight to the decision with both percents at 0
          state_nxt = in_data.supply_present ? fsc_pkg::ST_PREP : fsc_pkg::ST_DONE;
        end
      end
      fsc_pkg::ST_PREP: begin
        if (need_div) begin
          state_nxt = fsc_pkg::ST_DIV;
        end else if (ch_r) begin
          state_nxt = fsc_pkg::ST_DONE;
        end else begin
          state_nxt = fsc_pkg::ST_PREP;
        end
      end
      fsc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ch_r ? fsc_pkg::ST_DONE : fsc_pkg::ST_PREP;
        end
      end
      fsc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = fsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fsc_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and output updates
  // ---------------------------------------------------------------------------
  always_comb begin
    ch_nxt        = ch_r;
    np_nxt        = np_r;
    nh_nxt        = nh_r;
    last_cap_nxt  = last_cap_r;
    last_hs_nxt   = last_hs_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      fsc_pkg::ST_IDLE: begin
        ch_nxt = 1'b0;
        if (in_acc && !in_data.supply_present) begin
          np_nxt = '0;
          nh_nxt = '0;
        end
      end
      fsc_pkg::ST_PREP: begin
        if (!need_div) begin
          if (ch_r) begin
            nh_nxt = direct_pct;
          end else begin
            np_nxt = direct_pct;
          end
          ch_nxt = 1'b1;
        end
      end
      fsc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (ch_r) begin
            nh_nxt = div_rsp.quotient;
          end else begin
            np_nxt = div_rsp.quotient;
          end
          ch_nxt = 1'b1;
        end
      end
      fsc_pkg::ST_DONE: begin
        if (out_free) begin
          last_cap_nxt        = cap_dec.last;
          last_hs_nxt         = hs_dec.last;
          out_nxt.cap_command = cap_dec.cmd;
          out_nxt.cap_speed   = cap_dec.last;
          out_nxt.hs_command  = hs_dec.cmd;
          out_nxt.hs_speed    = hs_dec.last;
          out_valid_nxt       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsc_pkg::ST_IDLE;
      ch_r        <= 1'b0;
      last_cap_r  <= '0;
      last_hs_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      last_cap_r  <= last_cap_nxt;
      last_hs_r   <= last_hs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    np_r  <= np_nxt;
    nh_r  <= nh_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_stop_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.cap_command == fsc_pkg::CMD_STOP) |-> out_r.cap_speed == '0)
    else $error("capacitor stop with nonzero speed");

  a_set_speed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.hs_command == fsc_pkg::CMD_SET) |-> out_r.hs_speed != '0)
    else $error("heatsink set command with zero speed");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> div_rsp.quotient <= PCT_FULL)
    else $error("ramp quotient above full speed");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsc_pkg::ST_DIV) && !div_rsp.done |=> state_r == fsc_pkg::ST_DIV)
    else $error("sequencer left divide wait early");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> state_r == fsc_pkg::ST_DIV)
    else $error("divider running outside divide wait");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for dual_fan_speed_controller: a directed table, then random phases.
// Depends on fsc_pkg and the block's RTL; an internal predictor gives the expected results.
`timescale 1ns / 100ps

module tb;
  import fsc_pkg::*;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  fsc_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  fsc_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TEMP_W-1:0]    cfg_data;

  dual_fan_speed_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the curve registers and of the speeds
  // in force on both fans.
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] cap_on_t, cap_full_t, cap_off_t;
  logic signed [TEMP_W-1:0] hs_on_t, hs_full_t, hs_off_t;
  logic [PCT_W-1:0]         min_run, deadband;
  logic [PCT_W-1:0]         cap_pct_now, hs_pct_now;

  fsc_out_t fan_results_due[$];  // one entry per accepted request, oldest first
  int       mismatches;
  bit       calm;                // no idling on either side while set

  // Directed stimulus: a register write or a tick, with an optional typed result
  typedef struct {
    logic     is_cfg;
    fsc_reg_t idx;
    logic [TEMP_W-1:0] val;
    fsc_in_t  tick;
    logic     has_exp;
    fsc_out_t exp;
  } plan_row_t;

  plan_row_t tick_plan[$];

  function automatic logic signed [TEMP_W-1:0] clamp12(int v);
    if (v > 2047) return 12'sd2047;
    if (v < -2048) return -12'sd2048;
    return TEMP_W'(v);
  endfunction

  // Off / on / full curve for one channel
  function automatic logic [PCT_W-1:0] curve_pct(logic ok, int t, int on_t, int full_t,
                                                 int off_t, logic [PCT_W-1:0] held);
    int num;
    int den;
    if (!ok) return held;
    if (t <= off_t) return '0;
    if (t < on_t) return held;
    if (t >= full_t) return 7'd100;
    num = 100 * (t - on_t);
    den = full_t - on_t;
    // small nonzero ramp values are lifted to the minimum run speed
    if (num > 0 && num < int'(min_run) * den) return min_run;
    return PCT_W'((2 * num + den) / (2 * den));  // nearest, halves up
  endfunction

  function automatic fsc_cmd_t speed_cmd(logic [PCT_W-1:0] n, logic [PCT_W-1:0] held);
    int diff;
    diff = (n > held) ? n - held : held - n;
    if (n == 0) return (held != 0) ? CMD_STOP : CMD_NONE;
    if (diff >= int'(deadband)) return CMD_SET;
    return CMD_NONE;
  endfunction

  // Advance both fans by one tick and return the result it should produce
  function automatic fsc_out_t advance_fans(fsc_in_t d);
    fsc_out_t         r;
    fsc_cmd_t         cc;
    fsc_cmd_t         hc;
    logic [PCT_W-1:0] np;
    logic [PCT_W-1:0] nh;
    int               tcap;
    cc = CMD_NONE;
    hc = CMD_NONE;
    if (!d.supply_present) begin
      // no supply: stop whatever runs
      if (cap_pct_now != 0) begin
        cc = CMD_STOP;
        cap_pct_now = '0;
      end
      if (hs_pct_now != 0) begin
        hc = CMD_STOP;
        hs_pct_now = '0;
      end
    end else begin
      tcap = 0;
      if (d.board0_valid && d.board1_valid)
        tcap = (d.board0_temp > d.board1_temp) ? d.board0_temp : d.board1_temp;
      else if (d.board0_valid)
        tcap = d.board0_temp;
      else if (d.board1_valid)
        tcap = d.board1_temp;
      np = curve_pct(d.board0_valid || d.board1_valid, tcap, cap_on_t, cap_full_t,
                     cap_off_t, cap_pct_now);
      nh = curve_pct(d.heatsink_valid, d.heatsink_temp, hs_on_t, hs_full_t, hs_off_t,
                     hs_pct_now);
      cc = speed_cmd(np, cap_pct_now);
      hc = speed_cmd(nh, hs_pct_now);
      if (cc == CMD_STOP) cap_pct_now = '0;
      else if (cc == CMD_SET) cap_pct_now = np;
      if (hc == CMD_STOP) hs_pct_now = '0;
      else if (hc == CMD_SET) hs_pct_now = nh;
    end
    r.cap_command = cc;
    r.cap_speed   = cap_pct_now;
    r.hs_command  = hc;
    r.hs_speed    = hs_pct_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Temperatures clustered on the thresholds of the curve now in force
  function automatic logic signed [TEMP_W-1:0] pick_temp(int off_t, int on_t, int full_t);
    int lo;
    int hi;
    int v;
    case ($urandom_range(0, 8))
      0: v = off_t - int'($urandom_range(0, 60));
      1: v = off_t;
      2: begin
        lo = (off_t < on_t) ? off_t : on_t;
        hi = (off_t < on_t) ? on_t : off_t;
        v  = lo + int'($urandom_range(0, hi - lo));
      end
      3: v = on_t;
      4: begin
        lo = (on_t < full_t) ? on_t : full_t;
        hi = (on_t < full_t) ? full_t : on_t;
        v  = lo + int'($urandom_range(0, hi - lo));
      end
      5: v = full_t;
      6: v = full_t + int'($urandom_range(0, 60));
      7: v = on_t + int'($urandom_range(0, 3));  // just onto the ramp: minimum run
      default: v = int'($urandom_range(0, 4095)) - 2048;
    endcase
    return clamp12(v);
  endfunction

  function automatic fsc_in_t random_tick();
    fsc_in_t t;
    t.supply_present = ($urandom_range(0, 9) != 0);
    t.heatsink_temp  = pick_temp(hs_off_t, hs_on_t, hs_full_t);
    t.heatsink_valid = ($urandom_range(0, 4) != 0);
    t.board0_temp    = pick_temp(cap_off_t, cap_on_t, cap_full_t);
    t.board0_valid   = ($urandom_range(0, 4) != 0);
    t.board1_temp    = pick_temp(cap_off_t, cap_on_t, cap_full_t);
    t.board1_valid   = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 9) == 0) begin
      // noise: every field random
      t.supply_present = $urandom_range(0, 1);
      t.heatsink_temp  = TEMP_W'($urandom);
      t.heatsink_valid = $urandom_range(0, 1);
      t.board0_temp    = TEMP_W'($urandom);
      t.board0_valid   = $urandom_range(0, 1);
      t.board1_temp    = TEMP_W'($urandom);
      t.board1_valid   = $urandom_range(0, 1);
    end
    return t;
  endfunction

  function automatic plan_row_t tick_row(logic sp, int hs_t, logic hs_v, int b0_t, logic b0_v,
                                         int b1_t, logic b1_v);
    plan_row_t r;
    r.is_cfg              = 1'b0;
    r.idx                 = REG_CAP_ON;
    r.val                 = '0;
    r.tick.supply_present = sp;
    r.tick.heatsink_temp  = TEMP_W'(hs_t);
    r.tick.heatsink_valid = hs_v;
    r.tick.board0_temp    = TEMP_W'(b0_t);
    r.tick.board0_valid   = b0_v;
    r.tick.board1_temp    = TEMP_W'(b1_t);
    r.tick.board1_valid   = b1_v;
    r.has_exp             = 1'b0;
    r.exp                 = '0;
    return r;
  endfunction

  function automatic plan_row_t with_result(plan_row_t r, fsc_cmd_t cc, int cs, fsc_cmd_t hc,
                                            int hsp);
    r.has_exp         = 1'b1;
    r.exp.cap_command = cc;
    r.exp.cap_speed   = PCT_W'(cs);
    r.exp.hs_command  = hc;
    r.exp.hs_speed    = PCT_W'(hsp);
    return r;
  endfunction

  function automatic plan_row_t cfg_row(fsc_reg_t idx, logic [TEMP_W-1:0] val);
    plan_row_t r;
    r         = tick_row(1'b0, 0, 1'b0, 0, 1'b0, 0, 1'b0);
    r.is_cfg  = 1'b1;
    r.idx     = idx;
    r.val     = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers. Every drive happens in the time step of a rising edge.
  // ---------------------------------------------------------------------------
  // One register write; the predictor takes the value when the request goes in
  task automatic cfg_write(fsc_reg_t idx, logic [TEMP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CAP_ON:   cap_on_t   = val;
      REG_CAP_FULL: cap_full_t = val;
      REG_CAP_OFF:  cap_off_t  = val;
      REG_HS_ON:    hs_on_t    = val;
      REG_HS_FULL:  hs_full_t  = val;
      REG_HS_OFF:   hs_off_t   = val;
      REG_MIN_RUN:  min_run    = val[PCT_W-1:0];
      REG_DEADBAND: deadband   = val[PCT_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the tick request and wait until every result is back and the
  // sequencer is idle again; registers may only change then.
  task automatic settle_idle();
    if (in_valid) in_valid <= 1'b0;
    while (fan_results_due.size() != 0 || !in_ready) @(posedge clk);
  endtask

  // One tick request; the typed result, where given, stands in for the prediction
  task automatic send_tick(fsc_in_t d, logic typed, fsc_out_t want);
    int       gap;
    fsc_out_t got;
    if (cfg_valid) cfg_valid <= 1'b0;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    got = advance_fans(d);  // keeps the predictor state in step either way
    fan_results_due.push_back(typed ? want : got);
  endtask

  // Curve registers of one channel for a random phase
  task automatic program_channel(fsc_reg_t on_reg, fsc_reg_t full_reg, fsc_reg_t off_reg,
                                 int mode, int p);
    int off_t;
    int on_t;
    int full_t;
    case (mode)
      1: begin
        if (p < 4) begin
          // widest curve
          off_t  = -2048;
          on_t   = -2048;
          full_t = 2047;
        end else begin
          // narrowest curve at the top of the range
          off_t  = 2045;
          on_t   = 2046;
          full_t = 2047;
        end
      end
      2: begin
        // anything, thresholds in any order
        off_t  = int'($urandom_range(0, 4095)) - 2048;
        on_t   = int'($urandom_range(0, 4095)) - 2048;
        full_t = int'($urandom_range(0, 4095)) - 2048;
      end
      default: begin
        off_t  = -800 + int'($urandom_range(0, 2000));
        on_t   = off_t + int'($urandom_range(0, 200));
        full_t = on_t + 1 + int'($urandom_range(0, 400));
      end
    endcase
    cfg_write(on_reg, clamp12(on_t));
    cfg_write(full_reg, clamp12(full_t));
    cfg_write(off_reg, clamp12(off_t));
  endtask

  // Every register once per phase; upper data bits of the 7-bit ones are junk
  task automatic program_phase(int p);
    int mode;
    int mr;
    int db;
    mode = (p % 4 == 1) ? 1 : (p % 4 == 3) ? 2 : 0;
    program_channel(REG_CAP_ON, REG_CAP_FULL, REG_CAP_OFF, mode, p);
    program_channel(REG_HS_ON, REG_HS_FULL, REG_HS_OFF, mode, p);
    case (mode)
      1: begin
        mr = (p < 4) ? 0 : 100;
        db = (p < 4) ? 100 : 0;
      end
      2: begin
        mr = $urandom_range(0, 127);
        db = $urandom_range(0, 127);
      end
      default: begin
        mr = $urandom_range(0, 40);
        db = $urandom_range(0, 15);
      end
    endcase
    cfg_write(REG_MIN_RUN, {5'($urandom), PCT_W'(mr)});
    cfg_write(REG_DEADBAND, {5'($urandom), PCT_W'(db)});
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, compare against the oldest expectation
  // ---------------------------------------------------------------------------
  int sink_hold;

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else begin
      sink_hold = calm ? 0 : pick_gap();
      out_ready <= (sink_hold == 0);
    end
  end

  task automatic check_field(string name, logic [PCT_W-1:0] want, logic [PCT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    fsc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (fan_results_due.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = fan_results_due.pop_front();
        check_field("cap_command", want.cap_command, out_data.cap_command);
        check_field("cap_speed", want.cap_speed, out_data.cap_speed);
        check_field("hs_command", want.hs_command, out_data.hs_command);
        check_field("hs_speed", want.hs_speed, out_data.hs_speed);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int        i;
    int        p;
    int        n;
    plan_row_t row;

    // known values on every input from time zero
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    sink_hold  = 0;
    mismatches = 0;
    calm       = 1'b0;

    // register values and speeds after reset
    cap_on_t    = 12'sd720;
    cap_full_t  = 12'sd960;
    cap_off_t   = 12'sd640;
    hs_on_t     = 12'sd800;
    hs_full_t   = 12'sd1120;
    hs_off_t    = 12'sd720;
    min_run     = 7'd20;
    deadband    = 7'd5;
    cap_pct_now = '0;
    hs_pct_now  = '0;

    // Directed part, reset curve first (cap 640/720/960, heatsink 720/800/1120)
    // fresh out of reset, no supply: nothing to stop
    tick_plan.push_back(with_result(tick_row(0, 0, 0, 0, 0, 0, 0), CMD_NONE, 0, CMD_NONE, 0));
    // hottest readings: both fans straight to full
    tick_plan.push_back(with_result(tick_row(1, 2047, 1, 2047, 1, 0, 0),
                                    CMD_SET, 100, CMD_SET, 100));
    // supply lost: both running fans stop
    tick_plan.push_back(with_result(tick_row(0, 2047, 1, 2047, 1, 2047, 1),
                                    CMD_STOP, 0, CMD_STOP, 0));
    // supply still lost, already stopped
    tick_plan.push_back(with_result(tick_row(0, 2047, 1, 2047, 1, 2047, 1),
                                    CMD_NONE, 0, CMD_NONE, 0));
    // every reading invalid: hold
    tick_plan.push_back(with_result(tick_row(1, 2047, 0, 2047, 0, 2047, 0),
                                    CMD_NONE, 0, CMD_NONE, 0));
    // coldest readings
    tick_plan.push_back(with_result(tick_row(1, -2048, 1, -2048, 1, -2048, 1),
                                    CMD_NONE, 0, CMD_NONE, 0));
    // on the ramp, board1 hotter
    tick_plan.push_back(tick_row(1, 960, 1, 800, 1, 900, 1));
    // change below the deadband
    tick_plan.push_back(tick_row(1, 965, 1, 905, 1, 0, 0));
    // barely onto the ramp: minimum run
    tick_plan.push_back(tick_row(1, 801, 1, 722, 1, -2048, 0));
    // inside the hysteresis band: hold
    tick_plan.push_back(tick_row(1, 750, 1, 700, 0, 700, 1));
    // exactly at off
    tick_plan.push_back(with_result(tick_row(1, 720, 1, 640, 1, 600, 1),
                                    CMD_STOP, 0, CMD_STOP, 0));
    // exactly at on: ramp gives zero
    tick_plan.push_back(with_result(tick_row(1, 800, 1, 720, 1, 0, 0),
                                    CMD_NONE, 0, CMD_NONE, 0));
    // exactly at full
    tick_plan.push_back(with_result(tick_row(1, 1120, 1, 960, 0, 960, 1),
                                    CMD_SET, 100, CMD_SET, 100));
    // ramp value on an exact half; heatsink invalid holds
    tick_plan.push_back(tick_row(1, 2047, 0, 2047, 0, 774, 1));
    // board0 hotter than board1
    tick_plan.push_back(tick_row(1, -2048, 1, 950, 1, -2048, 1));
    // zero deadband: an unchanged speed is commanded again
    tick_plan.push_back(cfg_row(REG_DEADBAND, 12'd0));
    tick_plan.push_back(tick_row(1, 960, 1, 900, 1, 0, 0));
    tick_plan.push_back(tick_row(1, 960, 1, 900, 1, 0, 0));
    // minimum run above 100, written with all data bits set
    tick_plan.push_back(cfg_row(REG_MIN_RUN, 12'hFFF));
    tick_plan.push_back(tick_row(1, 801, 1, 721, 1, 0, 0));
    // capacitor thresholds in reverse order
    tick_plan.push_back(cfg_row(REG_CAP_ON, 12'h7FF));
    tick_plan.push_back(cfg_row(REG_CAP_FULL, 12'h800));
    tick_plan.push_back(cfg_row(REG_CAP_OFF, 12'h800));
    tick_plan.push_back(tick_row(1, 0, 1, 0, 1, 0, 0));
    tick_plan.push_back(tick_row(1, 0, 1, 2047, 1, 0, 0));
    tick_plan.push_back(tick_row(1, 0, 1, -2048, 1, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < tick_plan.size(); i++) begin
      row = tick_plan[i];
      if (row.is_cfg) begin
        settle_idle();
        cfg_write(row.idx, row.val);
      end else begin
        send_tick(row.tick, row.has_exp, row.exp);
      end
    end

    // Random phases: new registers each time, one phase without idling
    for (p = 0; p < 8; p++) begin
      settle_idle();
      calm = (p == 2);
      program_phase(p);
      for (n = 0; n < 50; n++) send_tick(random_tick(), 1'b0, '0);
    end

    // drain, then give the block time to show a stray result
    if (in_valid) in_valid <= 1'b0;
    calm = 1'b0;
    while (fan_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== dual_fan_speed_controller.f =====
rtl/core/fsc_pkg.sv
rtl/core/fsc_div.sv
rtl/core/dual_fan_speed_controller.sv
dv/tb.sv
